/* hdl/bypass_bin_debinarizer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bypass bin debinarizer
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BYPASS_BIN_DEBINARIZER_ASSERT_SVH
`define BYPASS_BIN_DEBINARIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bbd_pkg.sv */
// ----------------------------------------------------------------------------
// Bypass bin debinarizer package
// Shared types and constants for the debinarizer modules.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int unsigned VAL_W          = 34;
  localparam int unsigned PARAM_W        = 6;
  localparam int unsigned BASE_W         = 6;
  localparam int unsigned PARAM_MAX      = 32;
  localparam int unsigned MAX_PREFIX_DEF = 31;
  // Rice prefixes at or above this length switch to the exp-Golomb escape.
  localparam int unsigned RICE_ESC       = 3;

  typedef enum logic [1:0] {
    OP_RICE  = 2'd0,
    OP_EGK   = 2'd1,
    OP_FIXED = 2'd2,
    OP_TU    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [PARAM_W-1:0] param;
    logic [BASE_W-1:0]  base;
    logic               bin;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             capped;
  } result_t;

endpackage

/* hdl/bbd_in_reg.sv */
// ----------------------------------------------------------------------------
// Input register stage
// Holds one accepted bin transaction until the decode step consumes it.
// ----------------------------------------------------------------------------
module bbd_in_reg
  import bbd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  adv_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  vld_q, vld_d;
  item_t item_q;

  assign ready_o = !vld_q || adv_i;
  assign vld_d   = ready_o ? valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

/* hdl/bbd_core.sv */
// ----------------------------------------------------------------------------
// Debinarizer decode step
// Element state registers and the combinational update for one bin.
// ----------------------------------------------------------------------------
module bbd_core
  import bbd_pkg::*;
#(
  parameter int unsigned MAX_PREFIX = MAX_PREFIX_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  output logic    res_vld_o,
  output result_t res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PREFIX + 1);
  localparam int unsigned BL_W  = $clog2(MAX_PREFIX - RICE_ESC + PARAM_MAX + 1);
  localparam int unsigned M_W   = MAX_PREFIX - 2;
  localparam int unsigned SH_W  = M_W + PARAM_MAX;
  localparam int unsigned SUM_W = PARAM_W + 1;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  logic               busy_q, busy_d;
  logic               sfx_q, sfx_d;
  op_e                op_q, op_d;
  logic [PARAM_W-1:0] param_q, param_d;
  logic [CNT_W-1:0]   pc_q, pc_d;
  logic [BL_W-1:0]    bl_q, bl_d;
  logic [VAL_W-1:0]   acc_q, acc_d;
  logic               cap_q, cap_d;

  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
  endfunction

  always_comb begin
    logic               emit;
    logic               early;
    logic               done;
    op_e                e_op;
    logic [PARAM_W-1:0] e_param;
    logic [CNT_W-1:0]   e_pc;
    logic [BL_W-1:0]    e_bl;
    logic [VAL_W-1:0]   e_acc;
    logic               e_sfx;
    logic               e_cap;
    logic [CNT_W-1:0]   pc_inc;
    logic [CNT_W-1:0]   p3;
    logic [BL_W-1:0]    pos;
    logic [M_W-1:0]     mant;
    logic [SH_W-1:0]    shifted;
    logic [SUM_W-1:0]   egk_sh;
    logic [SUM_W-1:0]   egk_n;

    emit    = 1'b0;
    early   = 1'b0;
    done    = 1'b0;
    p3      = '0;
    pos     = '0;
    mant    = '0;
    shifted = '0;

    if (!busy_q) begin
      e_op    = item_i.op;
      e_param = (item_i.param > PARAM_W'(PARAM_MAX)) ? PARAM_W'(PARAM_MAX) : item_i.param;
      e_pc    = '0;
      e_bl    = '0;
      e_acc   = '0;
      e_sfx   = 1'b0;
      e_cap   = 1'b0;
      unique case (item_i.op)
        OP_EGK: begin
          e_acc = VAL_W'(item_i.base);
          if (SUM_W'(e_param) >= SUM_W'(MAX_PREFIX)) begin
            // Order already at the cap: no prefix, straight into the suffix.
            e_cap = 1'b1;
            e_sfx = 1'b1;
            e_bl  = BL_W'(e_param);
          end
        end
        OP_FIXED: begin
          if (e_param == '0) begin
            early = 1'b1;
          end else begin
            e_sfx = 1'b1;
            e_bl  = BL_W'(e_param);
          end
        end
        OP_TU: begin
          early = (e_param == '0);
        end
        OP_RICE: ;
        default: ;
      endcase
    end else begin
      e_op    = op_q;
      e_param = param_q;
      e_pc    = pc_q;
      e_bl    = bl_q;
      e_acc   = acc_q;
      e_sfx   = sfx_q;
      e_cap   = cap_q;
    end

    pc_inc = e_pc + CNT_W'(item_i.bin);
    egk_sh = SUM_W'(e_param) + SUM_W'(e_pc);
    egk_n  = SUM_W'(e_param) + SUM_W'(pc_inc);

    busy_d  = 1'b1;
    op_d    = e_op;
    param_d = e_param;
    pc_d    = e_pc;
    bl_d    = e_bl;
    acc_d   = e_acc;
    sfx_d   = e_sfx;
    cap_d   = e_cap;

    if (early) begin
      emit = 1'b1;
    end else if (e_sfx) begin
      pos  = e_bl - BL_W'(1);
      if (item_i.bin) begin
        // Bits at or above the value width can only push it into saturation.
        acc_d = (pos >= BL_W'(VAL_W)) ? VAL_MAX : sat_add(e_acc, VAL_W'(1) << pos);
      end
      bl_d = pos;
      emit = (pos == '0);
    end else begin
      unique case (e_op)
        OP_RICE: begin
          pc_d = pc_inc;
          if (item_i.bin && (pc_inc >= CNT_W'(MAX_PREFIX))) begin
            cap_d = 1'b1;
            done  = 1'b1;
          end else begin
            done = !item_i.bin;
          end
          if (done) begin
            if (pc_inc < CNT_W'(RICE_ESC)) begin
              acc_d = VAL_W'(pc_inc[1:0]) << e_param;
              bl_d  = BL_W'(e_param);
            end else begin
              p3      = pc_inc - CNT_W'(RICE_ESC);
              mant    = (M_W'(1) << p3) + M_W'(2);
              shifted = SH_W'(mant) << e_param;
              acc_d   = (|shifted[SH_W-1:VAL_W]) ? VAL_MAX : shifted[VAL_W-1:0];
              bl_d    = BL_W'(p3) + BL_W'(e_param);
            end
            emit  = (bl_d == '0);
            sfx_d = 1'b1;
          end
        end
        OP_EGK: begin
          pc_d = pc_inc;
          if (item_i.bin) begin
            acc_d = sat_add(e_acc, VAL_W'(1) << egk_sh);
            if (egk_n >= SUM_W'(MAX_PREFIX)) begin
              cap_d = 1'b1;
              done  = 1'b1;
            end
          end else begin
            done = 1'b1;
          end
          if (done) begin
            bl_d  = BL_W'(egk_n);
            emit  = (egk_n == '0);
            sfx_d = 1'b1;
          end
        end
        OP_TU: begin
          pc_d = pc_inc;
          if (item_i.bin && (SUM_W'(pc_inc) < SUM_W'(e_param))) begin
            if (pc_inc >= CNT_W'(MAX_PREFIX)) begin
              cap_d = 1'b1;
              emit  = 1'b1;
            end
          end else begin
            emit = 1'b1;
          end
          acc_d = VAL_W'(pc_inc);
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end

    res_vld_o    = emit;
    res_o.value  = early ? '0 : acc_d;
    res_o.capped = early ? 1'b0 : cap_d;

    if (emit) begin
      busy_d = 1'b0;
      sfx_d  = 1'b0;
      pc_d   = '0;
      bl_d   = '0;
      acc_d  = '0;
      cap_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      sfx_q   <= 1'b0;
      op_q    <= OP_RICE;
      param_q <= '0;
      pc_q    <= '0;
      bl_q    <= '0;
      acc_q   <= '0;
      cap_q   <= 1'b0;
    end else if (en_i) begin
      busy_q  <= busy_d;
      sfx_q   <= sfx_d;
      op_q    <= op_d;
      param_q <= param_d;
      pc_q    <= pc_d;
      bl_q    <= bl_d;
      acc_q   <= acc_d;
      cap_q   <= cap_d;
    end
  end

endmodule

/* hdl/bypass_bin_debinarizer.sv */
// ----------------------------------------------------------------------------
// Bypass bin debinarizer
// Rebuilds Rice/exp-Golomb, exp-Golomb k, fixed-length and truncated unary
// syntax element values from a stream of bypass bins.
// ----------------------------------------------------------------------------
// One bin transaction is accepted every cycle while the output side keeps up.
// When a finished value is held at the output, one more transaction fills the
// input register and the input then stalls until the value is taken. Each bin
// passes an input register, a combinational decode against the element
// state and an output register; a value is loaded into the output register
// when the transaction with the element's last bin leaves the input register.
// The rate is set by the element state update, which is combinational.
// Operation, parameter and base are taken from the first bin of an element
// and ignored on its later bins; prefix_capped marks a unary prefix that
// reached MAX_PREFIX ones; for exp-Golomb k, order plus prefix ones.
`include "bypass_bin_debinarizer_assert.svh"

module bypass_bin_debinarizer
  import bbd_pkg::*;
#(
  parameter int unsigned MAX_PREFIX = MAX_PREFIX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] param, [11:6] base, [12] bin, [15:13] zero
  input  logic [15:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [33:0] value, [39:34] zero
  output logic [39:0] m_axis_tdata,
  // [0] prefix_capped
  output logic        m_axis_tuser
);

  item_t   in_item;
  item_t   cur_item;
  logic    in_vld;
  logic    advance;
  logic    res_vld;
  result_t res;
  logic    out_vld_q, out_vld_d;
  result_t out_q;

  assign in_item.op    = op_e'(s_axis_tuser);
  assign in_item.param = s_axis_tdata[5:0];
  assign in_item.base  = s_axis_tdata[11:6];
  assign in_item.bin   = s_axis_tdata[12];

  bbd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .adv_i   (advance),
    .valid_o (in_vld),
    .item_o  (cur_item)
  );

  // The held bin moves on whenever the output register can take a value.
  assign advance = in_vld && (!out_vld_q || m_axis_tready);

  bbd_core #(
    .MAX_PREFIX (MAX_PREFIX)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .item_i    (cur_item),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  assign out_vld_d = (out_vld_q && !m_axis_tready) || (advance && res_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(40 - VAL_W){1'b0}}, out_q.value};
  assign m_axis_tuser  = out_q.capped;

  `BBD_ASSERT_SAME(a_in_empty_ready, !in_vld, s_axis_tready, "empty input stage not ready")
  `BBD_ASSERT_NEXT(a_res_loaded, advance && res_vld, m_axis_tvalid, "decoded value lost")
  `BBD_ASSERT_NEXT(a_bin_held, in_vld && !advance, in_vld, "stalled bin dropped")

endmodule
